// ===== rtl/qmn_pkg.sv =====
// shared constants and types for the normalised quaternion product
package qmn_pkg;

  localparam int COMP_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int LANES          = 4;
  localparam int NORM_TOP       = 29;
  localparam int Q_W            = NORM_TOP + 1;
  localparam int S_W            = 2 * Q_W + 2;
  localparam int L_W            = S_W / 2;

  // term t of component c is a[A_IDX[c][t]] * b[B_IDX[c][t]]
  localparam int A_IDX [LANES][LANES] = '{'{0, 1, 2, 3}, '{0, 1, 2, 3},
                                          '{0, 2, 3, 1}, '{0, 3, 1, 2}};
  localparam int B_IDX [LANES][LANES] = '{'{0, 1, 2, 3}, '{1, 0, 3, 2},
                                          '{2, 0, 1, 3}, '{3, 0, 2, 1}};
  // bit t set: term t is subtracted
  localparam logic [LANES-1:0] SUB_MASK [LANES] = '{4'b1110, 4'b1000,
                                                     4'b1000, 4'b1000};

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             zero;
  } qmn_flags_t;

  typedef struct packed {
    logic [LANES-1:0][Q_W-1:0] q;
    qmn_flags_t                flags;
  } qmn_side_t;

endpackage

// ===== rtl/qmn_isqrt.sv =====
// pipelined exact integer square root, one root bit per stage
module qmn_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [qmn_pkg::S_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [qmn_pkg::L_W-1:0]  out_root,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int LW = qmn_pkg::L_W;
  localparam int SW = qmn_pkg::S_W;
  localparam int RW = LW + 3;
  localparam int ST = LW;

  logic          v_r      [ST];
  logic [RW-1:0] rem_r    [ST];
  logic [LW-1:0] root_r   [ST];
  logic [SW-1:0] rad_r    [ST];
  logic [SIDE_W-1:0] side_r [ST];

  logic          src_v    [ST];
  logic [RW-1:0] src_rem  [ST];
  logic [LW-1:0] src_root [ST];
  logic [SW-1:0] src_rad  [ST];
  logic [SIDE_W-1:0] src_side [ST];

  logic [RW-1:0] rem_nxt  [ST];
  logic [LW-1:0] root_nxt [ST];
  logic [SW-1:0] rad_nxt  [ST];

  always_comb begin
    src_v[0]    = in_valid;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_rad[0]  = in_rad;
    src_side[0] = in_side;
    for (int k = 1; k < ST; k++) begin
      src_v[k]    = v_r[k-1];
      src_rem[k]  = rem_r[k-1];
      src_root[k] = root_r[k-1];
      src_rad[k]  = rad_r[k-1];
      src_side[k] = side_r[k-1];
    end
  end

  always_comb begin
    logic [RW-1:0] sh;
    logic [RW-1:0] trial;
    sh    = '0;
    trial = '0;
    for (int k = 0; k < ST; k++) begin
      sh    = {src_rem[k][RW-3:0], src_rad[k][SW-1 -: 2]};
      trial = {1'b0, src_root[k], 2'b01};
      if (sh >= trial) begin
        rem_nxt[k]  = sh - trial;
        root_nxt[k] = {src_root[k][LW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = sh;
        root_nxt[k] = {src_root[k][LW-2:0], 1'b0};
      end
      rad_nxt[k] = {src_rad[k][SW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ST; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < ST; k++) v_r[k] <= src_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ST; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        side_r[k] <= src_side[k];
      end
    end
  end

  assign out_valid = v_r[ST-1];
  assign out_root  = root_r[ST-1];
  assign out_side  = side_r[ST-1];

endmodule

// ===== rtl/qmn_div.sv =====
// pipelined restoring divider, four lanes sharing one divisor
module qmn_div #(
  parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF,
  localparam int QW = FRAC_BITS + 1
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       en,
  input  logic                                       in_valid,
  input  qmn_pkg::qmn_side_t                         in_side,
  input  logic [qmn_pkg::L_W-1:0]                    in_len,
  output logic                                       out_valid,
  output logic [qmn_pkg::LANES-1:0][QW-1:0]          out_quo,
  output qmn_pkg::qmn_flags_t                        out_flags
);

  localparam int LW  = qmn_pkg::L_W;
  localparam int NL  = qmn_pkg::LANES;
  localparam int NDW = qmn_pkg::Q_W + FRAC_BITS + 1;

  logic                n_v_r;
  logic [NDW-1:0]      n_r     [NL];
  logic [LW-1:0]       n_len_r;
  qmn_pkg::qmn_flags_t n_flags_r;

  logic                v_r     [QW];
  logic [LW-1:0]       rem_r   [QW][NL];
  logic [QW-1:0]       low_r   [QW][NL];
  logic [LW-1:0]       len_r   [QW];
  qmn_pkg::qmn_flags_t flags_r [QW];

  logic                src_v     [QW];
  logic [LW-1:0]       src_rem   [QW][NL];
  logic [QW-1:0]       src_low   [QW][NL];
  logic [LW-1:0]       src_len   [QW];
  qmn_pkg::qmn_flags_t src_flags [QW];

  logic [LW-1:0]       rem_nxt [QW][NL];
  logic [QW-1:0]       low_nxt [QW][NL];

  always_comb begin
    src_v[0]     = n_v_r;
    src_len[0]   = n_len_r;
    src_flags[0] = n_flags_r;
    for (int c = 0; c < NL; c++) begin
      src_rem[0][c] = LW'(n_r[c][NDW-1:QW]);
      src_low[0][c] = n_r[c][QW-1:0];
    end
    for (int k = 1; k < QW; k++) begin
      src_v[k]     = v_r[k-1];
      src_len[k]   = len_r[k-1];
      src_flags[k] = flags_r[k-1];
      for (int c = 0; c < NL; c++) begin
        src_rem[k][c] = rem_r[k-1][c];
        src_low[k][c] = low_r[k-1][c];
      end
    end
  end

  always_comb begin
    logic [LW:0] sh;
    logic [LW:0] dv;
    sh = '0;
    dv = '0;
    for (int k = 0; k < QW; k++) begin
      for (int c = 0; c < NL; c++) begin
        sh = {src_rem[k][c], src_low[k][c][QW-1]};
        dv = {1'b0, src_len[k]};
        if (sh >= dv) begin
          rem_nxt[k][c] = LW'(sh - dv);
          low_nxt[k][c] = {src_low[k][c][QW-2:0], 1'b1};
        end else begin
          rem_nxt[k][c] = LW'(sh);
          low_nxt[k][c] = {src_low[k][c][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
      for (int k = 0; k < QW; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      n_v_r <= in_valid;
      for (int k = 0; k < QW; k++) v_r[k] <= src_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NL; c++) begin
        n_r[c] <= (NDW'(in_side.q[c]) << FRAC_BITS) + NDW'(in_len >> 1);
      end
      n_len_r   <= in_len;
      n_flags_r <= in_side.flags;
      for (int k = 0; k < QW; k++) begin
        len_r[k]   <= src_len[k];
        flags_r[k] <= src_flags[k];
        for (int c = 0; c < NL; c++) begin
          rem_r[k][c] <= rem_nxt[k][c];
          low_r[k][c] <= low_nxt[k][c];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NL; c++) out_quo[c] = low_r[QW-1][c];
  end

  assign out_valid = v_r[QW-1];
  assign out_flags = flags_r[QW-1];

endmodule

// ===== rtl/quaternion_multiply_normalize.sv =====
// normalised hamilton quaternion product: top level
// Takes two quaternions per transaction and returns the unit quaternion a*b / |a*b|,
// rounded half away from zero, with out_tuser set and zero components when the product
// is zero. One transaction enters per cycle unless the pipeline is held. Results pass the
// input stages, the 31-stage square root, the divider (input register, FRAC_BITS + 1 quotient
// stages) and an output register. The whole pipeline holds while a finished result waits on out_tready.
module quaternion_multiply_normalize #(
  parameter int COMP_WIDTH = qmn_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = qmn_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((8 * COMP_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((4 * COMP_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // r_w, r_x, r_y, r_z
  output logic [0:0]       out_tuser   // zero_length
);

  localparam int CW   = COMP_WIDTH;
  localparam int NL   = qmn_pkg::LANES;
  localparam int QBW  = qmn_pkg::Q_W;
  localparam int PSH  = (CW > 31) ? 2 : 0;
  localparam int PRW  = 2 * CW - PSH;
  localparam int PW   = PRW + 2;
  localparam int NW   = (PW > QBW) ? PW : QBW;
  localparam int SHW  = $clog2(NW);
  localparam int QW   = FRAC_BITS + 1;
  localparam int XW   = (CW > QW + 1) ? CW : QW + 1;
  localparam int SQW  = 2 * QBW;
  localparam int NST  = 8;

  logic en;
  logic v_r [NST];

  logic signed [CW-1:0]  av [NL];
  logic signed [CW-1:0]  bv [NL];
  logic signed [2*CW-1:0] prod_full [NL][NL];

  logic signed [PRW-1:0] prod_r [NL][NL];
  logic signed [PW-1:0]  sum_nxt [NL];
  logic signed [PW-1:0]  sum_r   [NL];
  logic [PW-1:0]         mag_r   [NL];
  logic [NL-1:0]         neg3_r;
  logic [PW-1:0]         mag4_r  [NL];
  logic [PW-1:0]         max4_r;
  logic [NL-1:0]         neg4_r;
  logic [NW-1:0]         mag5_r  [NL];
  logic [SHW-1:0]        sh5_r;
  logic [SHW-1:0]        sh_nxt;
  qmn_pkg::qmn_flags_t   flags5_r;
  logic [NW-1:0]         shifted [NL];
  qmn_pkg::qmn_side_t    side6_r;
  logic [SQW-1:0]        sq7_r   [NL];
  qmn_pkg::qmn_side_t    side7_r;
  logic [qmn_pkg::S_W-1:0] s8_r;
  qmn_pkg::qmn_side_t    side8_r;

  logic [PW-1:0] mx01;
  logic [PW-1:0] mx23;

  logic                     sq_valid;
  logic [qmn_pkg::L_W-1:0]  sq_root;
  qmn_pkg::qmn_side_t       sq_side;
  logic                     dv_valid;
  logic [NL-1:0][QW-1:0]    dv_quo;
  qmn_pkg::qmn_flags_t      dv_flags;

  logic                  out_valid_r;
  logic [NL-1:0][CW-1:0] res_nxt;
  logic [NL-1:0][CW-1:0] res_r;
  logic                  zero_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      av[i] = in_tdata[i*CW +: CW];
      bv[i] = in_tdata[(i+NL)*CW +: CW];
    end
    for (int c = 0; c < NL; c++) begin
      for (int t = 0; t < NL; t++) begin
        prod_full[c][t] = av[qmn_pkg::A_IDX[c][t]] * bv[qmn_pkg::B_IDX[c][t]];
      end
    end
  end

  always_comb begin
    logic signed [PW-1:0] acc;
    acc = '0;
    for (int c = 0; c < NL; c++) begin
      acc = PW'(prod_r[c][0]);
      for (int t = 1; t < NL; t++) begin
        if (qmn_pkg::SUB_MASK[c][t]) acc = acc - PW'(prod_r[c][t]);
        else                         acc = acc + PW'(prod_r[c][t]);
      end
      sum_nxt[c] = acc;
    end
  end

  assign mx01 = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign mx23 = (mag_r[2] > mag_r[3]) ? mag_r[2] : mag_r[3];

  // leading one of the largest magnitude
  always_comb begin
    sh_nxt = '0;
    for (int i = 0; i < PW; i++) begin
      if (max4_r[i]) sh_nxt = SHW'(NW - 1 - i);
    end
  end

  always_comb begin
    for (int c = 0; c < NL; c++) shifted[c] = mag5_r[c] << sh5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int k = 1; k < NST; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NL; c++) begin
        for (int t = 0; t < NL; t++) begin
          prod_r[c][t] <= PRW'(prod_full[c][t] >>> PSH);
        end
        sum_r[c]  <= sum_nxt[c];
        mag_r[c]  <= sum_r[c][PW-1] ? PW'(-sum_r[c]) : PW'(sum_r[c]);
        mag4_r[c] <= mag_r[c];
        mag5_r[c] <= NW'(mag4_r[c]);
        side6_r.q[c] <= shifted[c][NW-1 -: QBW];
        sq7_r[c]  <= side6_r.q[c] * side6_r.q[c];
      end
      for (int c = 0; c < NL; c++) neg3_r[c] <= sum_r[c][PW-1];
      neg4_r         <= neg3_r;
      max4_r         <= (mx01 > mx23) ? mx01 : mx23;
      sh5_r          <= sh_nxt;
      flags5_r.neg   <= neg4_r;
      flags5_r.zero  <= (max4_r == '0);
      side6_r.flags  <= flags5_r;
      side7_r        <= side6_r;
      s8_r <= qmn_pkg::S_W'(sq7_r[0]) + qmn_pkg::S_W'(sq7_r[1])
            + qmn_pkg::S_W'(sq7_r[2]) + qmn_pkg::S_W'(sq7_r[3]);
      side8_r        <= side7_r;
    end
  end

  qmn_isqrt #(
    .SIDE_W ($bits(qmn_pkg::qmn_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r[NST-1]),
    .in_rad    (s8_r),
    .in_side   (side8_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  qmn_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .in_len    (sq_root),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_flags (dv_flags)
  );

  always_comb begin
    logic [XW-1:0] ext;
    ext = '0;
    for (int c = 0; c < NL; c++) begin
      ext = XW'(dv_quo[c]);
      if (dv_flags.neg[c]) ext = -ext;
      res_nxt[c] = dv_flags.zero ? '0 : ext[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      zero_r <= dv_flags.zero;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_W'(res_r);
  assign out_tuser[0] = zero_r;

endmodule

// ===== rtl/qmn_checker.sv =====
// port-level checks for the normalised quaternion product
module qmn_checker #(
  parameter int OUT_W = 64
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [0:0]       out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("zero length result with non-zero components");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input held off with empty output");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid && !out_tready)
    else $error("transaction refused without a waiting result");

endmodule

bind quaternion_multiply_normalize qmn_checker #(
  .OUT_W (OUT_W)
) u_qmn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== verif/tb_quaternion_multiply_normalize.sv =====
// testbench for the normalised quaternion product: directed and random transactions
`timescale 1ns / 100ps

module tb_quaternion_multiply_normalize;

  localparam int CW = qmn_pkg::COMP_WIDTH_DEF;
  localparam int FB = qmn_pkg::FRAC_BITS_DEF;
  localparam int IN_W = ((8 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((4 * CW + 7) / 8) * 8;
  localparam int LATENCY = 8 + 31 + FB + 3;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [OUT_W-1:0] comps;
    logic             zero_len;
  } unit_quat_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [0:0]       out_tuser;

  unit_quat_t expected_q[$];
  int         error_count;
  int         idle_cycles;
  bit         rx_hold;
  bit         rx_no_gaps;
  bit         tx_no_gaps;

  quaternion_multiply_normalize u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic unit_quat_t unit_product(logic [IN_W-1:0] d);
    longint          a [4];
    longint          b [4];
    longint          p [4];
    longint unsigned mag [4];
    longint unsigned m;
    longint unsigned s;
    longint unsigned len;
    longint unsigned r;
    int              e;
    unit_quat_t      res;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(d[i*CW +: CW]));
      b[i] = longint'($signed(d[(i+4)*CW +: CW]));
    end
    p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
    p[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
    p[2] = a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3];
    p[3] = a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1];
    m = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (p[i] < 0) ? longint'(-p[i]) : longint'(p[i]);
      if (mag[i] > m) m = mag[i];
    end
    res = '0;
    if (m == 0) begin
      res.zero_len = 1'b1;
      return res;
    end
    e = 0;
    while (e < 63 && (m >> (e + 1)) != 0) e++;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      if (e > qmn_pkg::NORM_TOP) mag[i] >>= (e - qmn_pkg::NORM_TOP);
      else mag[i] <<= (qmn_pkg::NORM_TOP - e);
      s += mag[i] * mag[i];
    end
    len = root_floor(s);
    if (len == 0) len = 1;
    for (int i = 0; i < 4; i++) begin
      r = ((mag[i] << FB) + (len >> 1)) / len;
      if (p[i] < 0) r = -r;
      res.comps[i*CW +: CW] = r[CW-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  always @(posedge clk) begin
    unit_quat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < 4; i++)
          if (out_tdata[i*CW +: CW] !== want.comps[i*CW +: CW])
            report_mismatch($sformatf("r[%0d]", i), $signed(out_tdata[i*CW +: CW]),
                            $signed(want.comps[i*CW +: CW]));
        if (out_tuser[0] !== want.zero_len)
          report_mismatch("zero_length", out_tuser[0], want.zero_len);
      end
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // receiver readiness
  initial begin
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (rx_no_gaps) begin
        out_tready <= 1'b1;
      end else begin
        n = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb_quaternion_multiply_normalize: done, errors");
      $finish;
    end
  end

  task automatic send_item(logic [IN_W-1:0] d);
    int n;
    n = (!tx_no_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tdata <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(unit_product(d));
  endtask

  function automatic logic [IN_W-1:0] pack_q(logic [CW-1:0] c[8]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 8; i++) d[i*CW +: CW] = c[i];
    return d;
  endfunction

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return CW'($urandom_range(0, 7)) - CW'(3);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [CW-1:0] c[8];
    logic [CW-1:0] one;
    one = CW'(1) << FB;
    c = '{default: '0};
    send_item(pack_q(c));
    c = '{one, '0, '0, '0, '0, '0, '0, '0};
    send_item(pack_q(c));
    c = '{one, '0, '0, '0, one, '0, '0, '0};
    send_item(pack_q(c));
    for (int i = 0; i < 4; i++) begin
      c = '{default: '0};
      c[i] = one;
      c[4 + (i + 1) % 4] = -one;
      send_item(pack_q(c));
    end
    c = '{default: {1'b1, {(CW-1){1'b0}}}};
    send_item(pack_q(c));
    c = '{default: {1'b0, {(CW-1){1'b1}}}};
    send_item(pack_q(c));
    c = '{default: {CW{1'b1}}};
    send_item(pack_q(c));
    for (int i = 0; i < 8; i++) c[i] = i[0] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    send_item(pack_q(c));
    c = '{CW'(1), '0, '0, '0, CW'(1), '0, '0, '0};
    send_item(pack_q(c));
    c = '{CW'(1), CW'(1), CW'(1), CW'(1), -CW'(1), CW'(1), CW'(1), CW'(1)};
    send_item(pack_q(c));
    c = '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
    send_item(pack_q(c));
    drain();
  endtask

  task automatic test_random(int count);
    logic [CW-1:0] c[8];
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 8; i++) c[i] = rand_comp();
      if ($urandom_range(0, 30) == 0) c[$urandom_range(0, 3)] = '0;
      if ($urandom_range(0, 40) == 0) for (int i = 0; i < 4; i++) c[i] = '0;
      send_item(pack_q(c));
    end
    drain();
  endtask

  task automatic test_backpressure();
    logic [CW-1:0] c[8];
    fork
      begin
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        tx_no_gaps = 1'b1;
        for (int k = 0; k < 150; k++) begin
          for (int i = 0; i < 8; i++) c[i] = CW'($urandom);
          send_item(pack_q(c));
        end
        tx_no_gaps = 1'b0;
      end
    join
    drain();
  endtask

  task automatic test_full_rate();
    rx_no_gaps = 1'b1;
    tx_no_gaps = 1'b1;
    test_random(200);
    rx_no_gaps = 1'b0;
    tx_no_gaps = 1'b0;
  endtask

  initial begin
    error_count = 0;
    rx_hold = 1'b0;
    rx_no_gaps = 1'b0;
    tx_no_gaps = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_full_rate();
    test_random(1180);
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_quaternion_multiply_normalize: done, clean");
    end else begin
      $display("tb_quaternion_multiply_normalize: done, errors");
    end
    $finish;
  end

endmodule
